>>> design/ssfm_pkg.sv
// Shared constants, register codes and types for the substring search block.
package ssfm_pkg;

  // Default window depth; the registers hold at most RegBytes needle bytes.
  localparam int NEEDLE_MAX_DEF = 16;
  localparam int RegBytes       = 16;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int COUNT_W = 32;

  // Configuration port: 64-bit registers at byte address 8*i.
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Control shared by every cell in the chain.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> design/ssfm_cell.sv
// One cell of the match chain: holds a partial-match flag for one needle offset.
module ssfm_cell (
  input  logic               clk,
  input  logic               rst,
  input  ssfm_pkg::cell_ctrl_t ctrl,
  input  ssfm_pkg::byte_t    hay_byte,
  input  ssfm_pkg::byte_t    needle_byte,
  input  logic               match_in,
  output logic               match_next,
  output logic               match_q
);
  import ssfm_pkg::*;

  // Extend the neighbour's partial match by the incoming byte.
  assign match_next = match_in && (hay_byte == needle_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (ctrl.clear) begin
      match_q <= 1'b0;
    end else if (ctrl.advance) begin
      match_q <= match_next;
    end
  end

endmodule

>>> design/substring_first_match_search.sv
// Top level of the streamed first-occurrence substring search.
// Finds the first occurrence of a needle of up to 16 bytes (fewer if NEEDLE_MAX is smaller)
// in a haystack that arrives one byte per transaction, the final byte flagged by last.
// Each haystack yields exactly one result transaction: found=1 with the start index at the
// byte that completes the first match, or found=0, position=0 at the final byte. Bytes after
// a match are absorbed until the final byte. An empty needle (pattern_len of zero, or a zero
// first needle byte) matches at position 0 on the first byte; pattern_len is clamped to the
// cell count and cut at the first zero needle byte. The byte counter saturates at 2^32-1.
// Takes one byte per cycle while the skid stage is free; results are registered. A chain of
// compare cells, one per needle offset, passes partial-match flags on to the next cell on
// each advancing byte; the cell at the effective needle length signals the hit. A result
// register and a skid stage let input flow while one result waits at the output. Write
// the needle only while no haystack is in flight; there is no clearing pass after reset.
module substring_first_match_search #(
  parameter int NEEDLE_MAX = ssfm_pkg::NEEDLE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssfm_pkg::ADDR_W-1:0] paddr,
  input  logic [ssfm_pkg::DATA_W-1:0] pwdata,
  output logic [ssfm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // haystack input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ssfm_pkg::byte_t             hay_byte,
  input  logic                        last,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output ssfm_pkg::count_t            position
);
  import ssfm_pkg::*;

  // Only as many cells as both the window and the registers allow.
  localparam int NCell = (NEEDLE_MAX < RegBytes) ? NEEDLE_MAX : RegBytes;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  len_t                   pattern_len;
  logic [DATA_W-1:0]      needle_low;
  logic [DATA_W-1:0]      needle_high;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
      needle_low  <= '0;
      needle_high <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_NEEDLE_LEN:  pattern_len <= pwdata[LEN_W-1:0];
        REG_NEEDLE_LOW:  needle_low  <= pwdata;
        REG_NEEDLE_HIGH: needle_high <= pwdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NEEDLE_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_len};
      REG_NEEDLE_LOW:  prdata = needle_low;
      REG_NEEDLE_HIGH: prdata = needle_high;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective needle length: clamp to the cell count, then cut at the first
  // zero byte (a zero byte terminates the needle string).
  // ---------------------------------------------------------------------------
  logic [2*DATA_W-1:0] needle_cat;
  len_t                len_clamped;
  len_t                eff_len;

  assign needle_cat  = {needle_high, needle_low};
  assign len_clamped = (pattern_len > LEN_W'(NCell)) ? LEN_W'(NCell) : pattern_len;

  always_comb begin
    eff_len = len_clamped;
    // Walk downwards so the lowest zero byte wins.
    for (int i = NCell - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < len_clamped) && (needle_cat[BYTE_W*i +: BYTE_W] == '0)) begin
        eff_len = LEN_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-haystack state
  // ---------------------------------------------------------------------------
  count_t     byte_count;
  count_t     count_inc;
  logic       match_reported;
  logic       accept;
  logic       advance;
  cell_ctrl_t cell_ctrl;

  assign accept    = in_valid && in_ready;
  // Once a match is reported, hold the chain and counter until the final byte.
  assign advance   = accept && !match_reported;
  assign count_inc = (byte_count == '1) ? byte_count : byte_count + COUNT_W'(1);

  assign cell_ctrl.advance = advance;
  assign cell_ctrl.clear   = accept && last;

  // ---------------------------------------------------------------------------
  // Match chain: cell j holds "needle bytes 0..j match the most recent j+1 bytes"
  // ---------------------------------------------------------------------------
  logic [NCell-1:0] match_q;
  logic [NCell-1:0] match_next;

  for (genvar j = 0; j < NCell; j++) begin : g_cell
    logic chain_in;
    if (j == 0) begin : g_head
      assign chain_in = 1'b1;
    end else begin : g_link
      assign chain_in = match_q[j-1];
    end

    ssfm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .hay_byte    (hay_byte),
      .needle_byte (needle_cat[BYTE_W*j +: BYTE_W]),
      .match_in    (chain_in),
      .match_next  (match_next[j]),
      .match_q     (match_q[j])
    );
  end

  // Hit when the cell at the effective length completes, or the needle is empty.
  logic hit;
  always_comb begin
    hit = (eff_len == '0);
    for (int j = 0; j < NCell; j++) begin
      if (match_next[j] && (eff_len == LEN_W'(j + 1))) begin
        hit = 1'b1;
      end
    end
  end

  logic   res_push;
  logic   res_found;
  count_t res_pos;

  assign res_push  = advance && (hit || last);
  assign res_found = hit;
  // An empty needle always reports position 0.
  assign res_pos   = (hit && (eff_len != '0)) ? (count_inc - COUNT_W'(eff_len)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
    end else if (accept && last) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
    end else if (advance) begin
      byte_count <= count_inc;
      if (hit) begin
        match_reported <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid stage
  // ---------------------------------------------------------------------------
  logic   skid_valid;
  logic   skid_found;
  count_t skid_pos;
  logic   pop;

  assign pop      = out_valid && out_ready;
  // Stall input only when both stages hold a result.
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        found    <= skid_found;
        position <= skid_pos;
      end
    end else if (res_push) begin
      if (!out_valid || pop) begin
        found    <= res_found;
        position <= res_pos;
      end else begin
        skid_found <= res_found;
        skid_pos   <= res_pos;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid stage filled without an output stall");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (byte_count == '0 && !match_reported && match_q == '0))
    else $error("haystack state not cleared after the final byte");

  a_miss_at_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (position == '0))
    else $error("miss result carries a nonzero position");

endmodule

>>> test/tb.sv
// Testbench for the streamed first-occurrence substring search block.
`timescale 1ns / 100ps

module tb;
  import ssfm_pkg::*;

  localparam int NeedleMax    = NEEDLE_MAX_DEF;
  localparam int NeedleLimit  = (NeedleMax < RegBytes) ? NeedleMax : RegBytes;
  localparam int TargetBytes  = 500;
  localparam int SettleCycles = 6;
  localparam int DrainLimit   = 5000;
  localparam int IdlePercent  = 36;
  localparam int HaysPerPhase = 6;

  // Register index past the end of the map: writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Score the result stream: track the needle settings and the stream state of
  // the block, and queue the verdict that each haystack should produce.
  class search_scoreboard;
    typedef struct packed {
      logic   found;
      count_t position;
    } verdict_t;

    len_t        pattern_len;
    logic [63:0] needle_lo;
    logic [63:0] needle_hi;
    byte_t       window [NeedleMax];
    count_t      seen;
    bit          matched;
    verdict_t    pending [$];
    int          errors;
    int          bytes_in;
    int          haystacks;
    int          results;
    int          hits;

    function new();
      pattern_len = '0;
      needle_lo   = '0;
      needle_hi   = '0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window[i]) window[i] = '0;
      seen    = '0;
      matched = 1'b0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_NEEDLE_LEN:  pattern_len = value[LEN_W-1:0];
        REG_NEEDLE_LOW:  needle_lo   = value;
        REG_NEEDLE_HIGH: needle_hi   = value;
        default: ;
      endcase
    endfunction

    function byte_t needle_at(int i);
      if (i < 8) return needle_lo[8*i +: 8];
      if (i < 16) return needle_hi[8*(i-8) +: 8];
      return '0;
    endfunction

    // Clamp to what the registers hold, then cut at the first zero byte.
    function int active_len();
      int n;
      n = (int'(pattern_len) > NeedleLimit) ? NeedleLimit : int'(pattern_len);
      for (int i = 0; i < n; i++) begin
        if (needle_at(i) == '0) return i;
      end
      return n;
    endfunction

    function void note_byte(byte_t b, logic is_last);
      count_t   cnt;
      int       n;
      bit       hit;
      verdict_t v;
      bytes_in++;
      if (!matched) begin
        cnt = (seen == '1) ? seen : seen + 1;
        for (int i = NeedleMax - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        n   = active_len();
        hit = 1'b0;
        v   = '0;
        if (n == 0) begin
          hit = 1'b1;
        end else if (cnt >= count_t'(n)) begin
          hit = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (window[i] != needle_at(n - 1 - i)) hit = 1'b0;
          end
          v.position = cnt - count_t'(n);
        end
        seen = cnt;
        if (hit) begin
          matched = 1'b1;
          v.found = 1'b1;
          pending.push_back(v);
          hits++;
        end else if (is_last) begin
          pending.push_back('0);
        end
      end
      if (is_last) begin
        haystacks++;
        clear_stream();
      end
    endfunction

    function void check_result(logic f, count_t p);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: found=%0b position=%0d", f, p);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (f !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, f);
        errors++;
      end
      if (p !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, p);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic             pready;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  byte_t            hay_byte  = '0;
  logic             last      = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             found;
  count_t           position;

  // When calm is set neither side idles.
  bit               calm      = 1'b0;
  int               settings  = 0;

  search_scoreboard sb = new();

  substring_first_match_search #(
    .NEEDLE_MAX(NeedleMax)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .hay_byte (hay_byte),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found    (found),
    .position (position)
  );

  // 10 ns clock: high half, then low half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall at random unless calm; drive on the falling edge only.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99, 0) >= IdlePercent);
  end

  // Sample both handshakes at the rising edge. Each accepted haystack byte
  // feeds the predictor; each accepted result is checked against the oldest
  // queued verdict.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(hay_byte, last);
    if (!rst && out_valid && out_ready) sb.check_result(found, position);
  end

  // Generous hard stop: a hung handshake ends the run here.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Register write: setup phase, then access phase; the register takes the
  // value at the edge where pready is seen high. Call and return at a falling edge.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Load a full needle setting. Junk goes into the unused bits of the length
  // register, since only its low bits count.
  task automatic set_needle(input int len, input logic [63:0] lo, input logic [63:0] hi);
    logic [DATA_W-1:0] len_word;
    len_word            = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len_t'(len);
    write_reg(REG_NEEDLE_LEN, len_word);
    write_reg(REG_NEEDLE_LOW, lo);
    write_reg(REG_NEEDLE_HIGH, hi);
    settings++;
  endtask

  // Offer one byte, idling first at random; hold it until accepted. Called and
  // left at a falling edge, so valid is never dropped and raised in one step.
  task automatic send_byte(input byte_t b, input logic is_last);
    while (!calm && $urandom_range(99, 0) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    hay_byte <= b;
    last     <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_haystack(input byte_t hay [$]);
    foreach (hay[k]) send_byte(hay[k], k == hay.size() - 1);
  endtask

  // Hold the sender until every queued verdict has come back, then give any
  // absorbed bytes time to leave the pipeline before the needle changes.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Draw a new needle. Some settings use a three-letter alphabet so that
  // haystacks hold many partial and overlapping matches.
  task automatic random_needle(input int phase);
    logic [63:0] lo;
    logic [63:0] hi;
    byte_t       b;
    bit          narrow;
    int          len;
    case (phase)
      0:       len = 16;
      1:       len = 1;
      2:       len = 0;
      3:       len = 31;
      default: len = ($urandom_range(5, 0) == 0) ? $urandom_range(31, 17)
                                                   : $urandom_range(16, 0);
    endcase
    narrow = $urandom_range(1, 0);
    for (int i = 0; i < 16; i++) begin
      b = narrow ? byte_t'(8'h61 + $urandom_range(2, 0)) : byte_t'($urandom_range(255, 1));
      if ($urandom_range(24, 0) == 0) b = '0;
      if (i < 8) lo[8*i +: 8] = b;
      else hi[8*(i-8) +: 8] = b;
    end
    set_needle(len, lo, hi);
  endtask

  // Mostly needle bytes, so that partial matches are common; now and then a
  // zero byte or a byte from the whole range.
  function automatic byte_t pick_byte(input int len);
    if (len > 0 && $urandom_range(9, 0) < 6) return sb.needle_at($urandom_range(len - 1, 0));
    if ($urandom_range(19, 0) == 0) return '0;
    return byte_t'($urandom_range(255, 1));
  endfunction

  // Most haystacks carry the needle planted at a random offset, some with one
  // byte spoilt; the rest are noise, often shorter than the needle.
  task automatic random_haystack();
    byte_t hay [$];
    int    len;
    int    n;
    int    at;
    int    mode;
    len  = sb.active_len();
    mode = $urandom_range(9, 0);
    if (len > 0 && mode < 7) n = len + $urandom_range(12, 0);
    else if ($urandom_range(19, 0) == 0) n = $urandom_range(48, 25);
    else n = $urandom_range(20, 1);
    for (int k = 0; k < n; k++) hay.push_back(pick_byte(len));
    if (len > 0 && mode < 7) begin
      at = $urandom_range(n - len, 0);
      for (int k = 0; k < len; k++) hay[at + k] = sb.needle_at(k);
      if (mode == 6) hay[at + $urandom_range(len - 1, 0)] ^= byte_t'($urandom_range(255, 1));
    end
    send_haystack(hay);
  endtask

  initial begin
    byte_t hay [$];
    int    phase;
    int    waited;

    // Hold reset, then release it on a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Reset settings give an empty needle: match at the first byte.
    hay = '{8'h41};
    send_haystack(hay);

    // Two-byte needle: a match inside the haystack, a haystack shorter than
    // the needle, and a zero byte next to the top byte value.
    wait_idle();
    set_needle(2, 64'h6261, 64'h0);
    hay = '{8'h78, 8'h61, 8'h62};
    send_haystack(hay);
    hay = '{8'h61};
    send_haystack(hay);
    hay = '{8'h00, 8'hFF};
    send_haystack(hay);

    // A zero needle byte ends the needle early: only "c" is left.
    wait_idle();
    set_needle(4, 64'h6564_0063, 64'h0);
    hay = '{8'h63};
    send_haystack(hay);

    // Zero first needle byte despite a nonzero length: empty needle, and the
    // second byte is absorbed after the match.
    wait_idle();
    set_needle(5, 64'h6161_6100, 64'h0);
    hay = '{8'h71, 8'h72};
    send_haystack(hay);

    // Length above the register capacity clamps to the full 16-byte needle;
    // the haystack is the needle itself. Also poke an unmapped register.
    wait_idle();
    set_needle(31, 64'h0706_0504_0302_01FF, 64'h80C0_E0F0_7F3F_1F01);
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    hay.delete();
    for (int k = 0; k < 16; k++) hay.push_back(sb.needle_at(k));
    send_haystack(hay);

    // Random part: a new needle per phase, a batch of haystacks each. One
    // phase runs with no idling on either side.
    phase = 0;
    while (sb.bytes_in < TargetBytes) begin
      wait_idle();
      random_needle(phase);
      calm = (phase == 4);
      repeat (HaysPerPhase) random_haystack();
      phase++;
    end
    calm = 1'b0;

    // Drain: bounded wait for outstanding verdicts, then let the pipeline settle.
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("Streamed %0d haystack bytes in %0d haystacks under %0d needle settings,",
             sb.bytes_in, sb.haystacks, settings);
    $display("checked %0d results of which %0d were matches.", sb.results, sb.hits);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ssfm_pkg.sv
design/ssfm_cell.sv
design/substring_first_match_search.sv
test/tb.sv
